// ===== hdl/sspwt_pkg.sv =====
`default_nettype none
package sspwt_pkg;

  localparam int KIND_W    = 2;
  localparam int DEST_W    = 6;
  localparam int WINDOW_W  = 16;
  localparam int SLEEP_W   = 20;
  localparam int MIF_W     = 16;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int CREDIT_W  = 22;
  localparam int PEN_MUL_W = 10;
  localparam int REG_IDX_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_SUCCESS = 2'd0,
    KIND_CONGEST = 2'd1,
    KIND_QUERY   = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  localparam logic [REG_IDX_W-1:0] REG_MAX_IN_FLIGHT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INITIAL_SLEEP = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_SLEEP     = 2'd2;

  localparam logic [MIF_W-1:0]   RST_MAX_IN_FLIGHT = 16'd32;
  localparam logic [SLEEP_W-1:0] RST_INITIAL_SLEEP = 20'd500;
  localparam logic [SLEEP_W-1:0] RST_MAX_SLEEP     = 20'd2000;

  localparam logic [CREDIT_W-WINDOW_W-1:0] STEP_CREDIT_MS = 6'd60;
  localparam logic [PEN_MUL_W-1:0]         RUN_PENALTY_MS = 10'd1000;
  localparam logic [WINDOW_W-1:0]          WIN_OUT_MAX    = 16'hFFFF;

endpackage
`default_nettype wire

// ===== hdl/sspwt_mem.sv =====
`default_nettype none
module sspwt_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sspwt_update.sv =====
`default_nettype none
module sspwt_update
  import sspwt_pkg::*;
#(
  parameter int CW   = 16,
  parameter int TH_W = 16
) (
  input  wire kind_t             kind,
  input  wire logic              fresh,
  input  wire logic [MIF_W-1:0]  max_in_flight,
  input  wire logic [CW-1:0]     cur_window,
  input  wire logic [TH_W-1:0]   cur_threshold,
  input  wire logic [CW-1:0]     cur_avoid,
  input  wire logic [CW-1:0]     cur_run,
  output logic      [CW-1:0]     new_window,
  output logic      [TH_W-1:0]   new_threshold,
  output logic      [CW-1:0]     new_avoid,
  output logic      [CW-1:0]     new_run
);

  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  localparam logic [CW-1:0] ONE     = CW'(1);

  logic [CW-1:0]   base_w;
  logic [TH_W-1:0] base_thr;
  logic [CW-1:0]   base_avoid;
  logic [CW-1:0]   base_run;
  logic [CW-1:0]   avoid_inc;
  logic [CW-1:0]   win_inc;
  logic [CW-1:0]   run_inc;

  always_comb begin
    if (fresh) begin
      base_w     = ONE;
      base_thr   = TH_W'(max_in_flight);
      base_avoid = '0;
      base_run   = '0;
    end else begin
      base_w     = cur_window;
      base_thr   = cur_threshold;
      base_avoid = cur_avoid;
      base_run   = cur_run;
    end
  end

  assign avoid_inc = (base_avoid == CNT_MAX) ? CNT_MAX : base_avoid + ONE;
  assign win_inc   = (base_w == CNT_MAX) ? CNT_MAX : base_w + ONE;
  assign run_inc   = (base_run == CNT_MAX) ? CNT_MAX : base_run + ONE;

  always_comb begin
    new_window    = base_w;
    new_threshold = base_thr;
    new_avoid     = base_avoid;
    new_run       = base_run;
    case (kind)
      KIND_SUCCESS: begin
        new_run = '0;
        if (TH_W'(base_w) >= base_thr) begin
          if (avoid_inc >= base_w) begin
            new_window = win_inc;
            new_avoid  = '0;
          end else begin
            new_avoid = avoid_inc;
          end
        end else begin
          new_window = win_inc;
        end
      end
      KIND_CONGEST: begin
        if (base_w <= ONE) begin
          new_window    = ONE;
          new_run       = run_inc;
          new_threshold = TH_W'(ONE);
        end else begin
          new_window    = base_w >> 1;
          new_threshold = TH_W'(base_w >> 1);
        end
        new_avoid = '0;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/sspwt_sleep.sv =====
`default_nettype none
module sspwt_sleep
  import sspwt_pkg::*;
#(
  parameter int CW   = 16,
  parameter int TH_W = 16
) (
  input  wire logic               clk,
  input  wire logic [CW-1:0]      window,
  input  wire logic [CW-1:0]      run,
  input  wire logic [MIF_W-1:0]   max_in_flight,
  input  wire logic [SLEEP_W-1:0] initial_sleep_ms,
  input  wire logic [SLEEP_W-1:0] max_sleep_ms,
  output logic      [SLEEP_W-1:0] sleep_ms
);

  localparam int PEN_W = CW + PEN_MUL_W;
  localparam int SUM_W = ((PEN_W > CREDIT_W) ? PEN_W : CREDIT_W) + 2;

  logic                       a_below;
  logic                       a_one;
  logic [CREDIT_W-1:0]        a_credit;
  logic [PEN_W-1:0]           a_pen;
  logic                       b_below;
  logic                       b_one;
  logic signed [SUM_W-1:0]    b_sum;
  logic signed [SUM_W-1:0]    cap;
  logic [WINDOW_W-1:0]        w_lo;
  logic                       w_one;

  assign w_lo  = WINDOW_W'(window);
  assign w_one = (window == CW'(1));

  always_ff @(posedge clk) begin
    a_below  <= TH_W'(window) < TH_W'(max_in_flight);
    a_one    <= w_one;
    a_credit <= CREDIT_W'(w_lo) * CREDIT_W'(STEP_CREDIT_MS);
    a_pen    <= w_one ? PEN_W'(run) * PEN_W'(RUN_PENALTY_MS) : '0;
    b_below  <= a_below;
    b_one    <= a_one;
    b_sum    <= $signed(SUM_W'(initial_sleep_ms) + SUM_W'(a_pen) - SUM_W'(a_credit));
  end

  assign cap = $signed(SUM_W'(max_sleep_ms));

  always_comb begin
    if (!b_below || b_sum < 0) begin
      sleep_ms = '0;
    end else if (b_one && b_sum > cap) begin
      sleep_ms = max_sleep_ms;
    end else begin
      sleep_ms = SLEEP_W'(b_sum);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/slow_start_push_window_table.sv =====
// Per-destination push-window table with slow start and halving on congestion.
// An input item carries kind (success, congestion, query or clear all) and
// dest_index, taken modulo DEST_COUNT. Each item yields exactly one result item
// with the entry's updated window and a sleep time in milliseconds; a clear
// yields zeros and invalidates every entry.
// Both channels use valid and stall. An item is taken when in_valid is high and
// in_stall is low. Its entry is read from the table, written back by the
// read-modify-write, and passed through the two sleep stages before the result
// enters the output register; the next item is taken the cycle after that at the
// earliest, so no new item is taken while one is being worked on. A finished
// result waits in the output register while out_stall is high, and the next item
// is still taken and worked on; it waits before the output register until the
// earlier result leaves. Reset invalidates all entries at once and loads the
// register defaults: max_in_flight 32, initial_sleep_ms 500, max_sleep_ms 2000.
// Registers are written over the APB port at byte addresses 0, 4 and 8; the user
// must do so only while the block is idle, as the block does not enforce it.
`default_nettype none
module slow_start_push_window_table
  import sspwt_pkg::*;
#(
  parameter int DEST_COUNT  = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [KIND_W-1:0]   kind,
  input  wire logic [DEST_W-1:0]   dest_index,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [WINDOW_W-1:0] window,
  output logic      [SLEEP_W-1:0]  sleep_ms,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic      [DATA_W-1:0]   prdata,
  output logic                     pready
);

  localparam int IDX_W  = (DEST_COUNT > 1) ? $clog2(DEST_COUNT) : 1;
  localparam int TH_W   = (COUNT_WIDTH > WINDOW_W) ? COUNT_WIDTH : WINDOW_W;
  localparam int WORD_W = 3 * COUNT_WIDTH + TH_W;
  localparam int IN_SPAN = 2 ** DEST_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_PROD = 5'b00100,
    ST_SUM  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [MIF_W-1:0]   max_in_flight;
  logic [SLEEP_W-1:0] initial_sleep_ms;
  logic [SLEEP_W-1:0] max_sleep_ms;
  logic               cfg_write;
  logic [REG_IDX_W-1:0] reg_idx;

  logic [IDX_W-1:0]   idx_tbl [IN_SPAN];
  logic [DEST_COUNT-1:0] entry_valid;
  logic               in_accept;
  logic [IDX_W-1:0]   in_idx;
  kind_t              kind_q;
  logic [IDX_W-1:0]   idx_q;

  logic [WORD_W-1:0]  rd_word;
  logic [WORD_W-1:0]  wr_word;
  logic               wr_en;

  logic [COUNT_WIDTH-1:0] cur_w;
  logic [TH_W-1:0]        cur_thr;
  logic [COUNT_WIDTH-1:0] cur_avoid;
  logic [COUNT_WIDTH-1:0] cur_run;
  logic [COUNT_WIDTH-1:0] new_w;
  logic [TH_W-1:0]        new_thr;
  logic [COUNT_WIDTH-1:0] new_avoid;
  logic [COUNT_WIDTH-1:0] new_run;

  logic [COUNT_WIDTH-1:0] upd_w;
  logic [COUNT_WIDTH-1:0] upd_run;
  logic [SLEEP_W-1:0]     calc_sleep;
  logic [WINDOW_W-1:0]    win_sat;
  logic                   out_load;

  // Configuration port.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_in_flight    <= RST_MAX_IN_FLIGHT;
      initial_sleep_ms <= RST_INITIAL_SLEEP;
      max_sleep_ms     <= RST_MAX_SLEEP;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_MAX_IN_FLIGHT: max_in_flight    <= pwdata[MIF_W-1:0];
        REG_INITIAL_SLEEP: initial_sleep_ms <= pwdata[SLEEP_W-1:0];
        REG_MAX_SLEEP:     max_sleep_ms     <= pwdata[SLEEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_IN_FLIGHT: prdata = DATA_W'(max_in_flight);
      REG_INITIAL_SLEEP: prdata = DATA_W'(initial_sleep_ms);
      REG_MAX_SLEEP:     prdata = DATA_W'(max_sleep_ms);
      default:           prdata = '0;
    endcase
  end

  // Destination index folded into the table depth.
  for (genvar g = 0; g < IN_SPAN; g++) begin : g_idx
    assign idx_tbl[g] = IDX_W'(g % DEST_COUNT);
  end

  assign in_idx    = idx_tbl[dest_index];
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    case (state)
      ST_IDLE: state_next = in_accept ? ST_READ : ST_IDLE;
      ST_READ: state_next = ST_PROD;
      ST_PROD: state_next = ST_SUM;
      ST_SUM:  state_next = ST_DONE;
      ST_DONE: state_next = out_load ? ST_IDLE : ST_DONE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_q <= kind_t'(kind);
      idx_q  <= in_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (in_accept && kind_t'(kind) == KIND_CLEAR) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[idx_q] <= 1'b1;
    end
  end

  // Entry table and its read-modify-write.
  assign wr_en   = (state == ST_READ) && (kind_q != KIND_CLEAR);
  assign wr_word = {new_run, new_avoid, new_thr, new_w};

  assign cur_w     = rd_word[COUNT_WIDTH-1:0];
  assign cur_thr   = rd_word[COUNT_WIDTH+TH_W-1:COUNT_WIDTH];
  assign cur_avoid = rd_word[2*COUNT_WIDTH+TH_W-1:COUNT_WIDTH+TH_W];
  assign cur_run   = rd_word[WORD_W-1:2*COUNT_WIDTH+TH_W];

  sspwt_mem #(
    .DEPTH (DEST_COUNT),
    .WIDTH (WORD_W),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (in_idx),
    .rd_data (rd_word),
    .wr_en   (wr_en),
    .wr_addr (idx_q),
    .wr_data (wr_word)
  );

  sspwt_update #(
    .CW   (COUNT_WIDTH),
    .TH_W (TH_W)
  ) u_update (
    .kind          (kind_q),
    .fresh         (!entry_valid[idx_q]),
    .max_in_flight (max_in_flight),
    .cur_window    (cur_w),
    .cur_threshold (cur_thr),
    .cur_avoid     (cur_avoid),
    .cur_run       (cur_run),
    .new_window    (new_w),
    .new_threshold (new_thr),
    .new_avoid     (new_avoid),
    .new_run       (new_run)
  );

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      upd_w   <= new_w;
      upd_run <= new_run;
    end
  end

  sspwt_sleep #(
    .CW   (COUNT_WIDTH),
    .TH_W (TH_W)
  ) u_sleep (
    .clk              (clk),
    .window           (upd_w),
    .run              (upd_run),
    .max_in_flight    (max_in_flight),
    .initial_sleep_ms (initial_sleep_ms),
    .max_sleep_ms     (max_sleep_ms),
    .sleep_ms         (calc_sleep)
  );

  // Output register.
  assign win_sat  = (TH_W'(upd_w) > TH_W'(WIN_OUT_MAX)) ? WIN_OUT_MAX : WINDOW_W'(upd_w);
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (kind_q == KIND_CLEAR) begin
        window   <= '0;
        sleep_ms <= '0;
      end else begin
        window   <= win_sat;
        sleep_ms <= calc_sleep;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb_slow_start_push_window_table.sv =====
`timescale 1ns / 100ps
module tb_slow_start_push_window_table
  import sspwt_pkg::*;
();

  localparam int TABLE_DEPTH  = 64;
  localparam int STALL_LIMIT  = 3000;
  localparam int PHASE_COUNT  = 8;
  localparam int PHASE_ITEMS  = 131;
  localparam int LONG_HOLD    = 300;
  localparam logic [ADDR_W-1:0] SPARE_ADDR = 4'd12;
  localparam logic [WINDOW_W-1:0] COUNT_TOP = 16'hFFFF;

  typedef struct packed {
    logic [WINDOW_W-1:0] window;
    logic [SLEEP_W-1:0]  sleep_ms;
  } push_answer_t;

  typedef struct packed {
    kind_t               k;
    logic [DEST_W-1:0]   d;
    logic                given;
    logic [WINDOW_W-1:0] w;
    logic [SLEEP_W-1:0]  s;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [KIND_W-1:0]   kind;
  logic [DEST_W-1:0]   dest_index;
  logic                out_valid;
  logic                out_stall;
  logic [WINDOW_W-1:0] window;
  logic [SLEEP_W-1:0]  sleep_ms;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic                row_given;
  logic [WINDOW_W-1:0] row_win;
  logic [SLEEP_W-1:0]  row_sleep;

  logic [MIF_W-1:0]    cfg_mif        = RST_MAX_IN_FLIGHT;
  logic [SLEEP_W-1:0]  cfg_init_sleep = RST_INITIAL_SLEEP;
  logic [SLEEP_W-1:0]  cfg_max_sleep  = RST_MAX_SLEEP;

  bit                  live      [TABLE_DEPTH] = '{default: 1'b0};
  logic [WINDOW_W-1:0] win_tab   [TABLE_DEPTH];
  logic [WINDOW_W-1:0] thr_tab   [TABLE_DEPTH];
  logic [WINDOW_W-1:0] avoid_tab [TABLE_DEPTH];
  logic [WINDOW_W-1:0] run_tab   [TABLE_DEPTH];

  push_answer_t owed_results [$];
  push_answer_t predicted;
  push_answer_t oldest;

  int fail_count   = 0;
  int items_taken  = 0;
  int results_seen = 0;
  int idle_count   = 0;
  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int hold_cycles       = 0;

  stim_row_t directed_rows [22] = '{
    '{KIND_QUERY,   6'd0,  1'b1, 16'd1, 20'd440},
    '{KIND_SUCCESS, 6'd1,  1'b1, 16'd2, 20'd380},
    '{KIND_SUCCESS, 6'd1,  1'b0, 16'd0, 20'd0},
    '{KIND_CONGEST, 6'd2,  1'b1, 16'd1, 20'd1440},
    '{KIND_CONGEST, 6'd2,  1'b1, 16'd1, 20'd2000},
    '{KIND_QUERY,   6'd2,  1'b0, 16'd0, 20'd0},
    '{KIND_CONGEST, 6'd1,  1'b0, 16'd0, 20'd0},
    '{KIND_SUCCESS, 6'd1,  1'b0, 16'd0, 20'd0},
    '{KIND_SUCCESS, 6'd1,  1'b0, 16'd0, 20'd0},
    '{KIND_SUCCESS, 6'd1,  1'b0, 16'd0, 20'd0},
    '{KIND_SUCCESS, 6'd2,  1'b0, 16'd0, 20'd0},
    '{KIND_CLEAR,   6'd0,  1'b1, 16'd0, 20'd0},
    '{KIND_QUERY,   6'd1,  1'b1, 16'd1, 20'd440},
    '{KIND_CLEAR,   6'd63, 1'b1, 16'd0, 20'd0},
    '{KIND_SUCCESS, 6'd63, 1'b1, 16'd2, 20'd380},
    '{KIND_CONGEST, 6'd63, 1'b0, 16'd0, 20'd0},
    '{KIND_CONGEST, 6'd63, 1'b0, 16'd0, 20'd0},
    '{KIND_SUCCESS, 6'd63, 1'b0, 16'd0, 20'd0},
    '{KIND_QUERY,   6'd63, 1'b0, 16'd0, 20'd0},
    '{KIND_SUCCESS, 6'd42, 1'b0, 16'd0, 20'd0},
    '{KIND_SUCCESS, 6'd21, 1'b0, 16'd0, 20'd0},
    '{KIND_CONGEST, 6'd42, 1'b0, 16'd0, 20'd0}
  };

  logic [DATA_W-1:0] phase_mif  [PHASE_COUNT] = '{
    32'd32, 32'd4, 32'd1, 32'hFFFF_0000, 32'd65535, 32'd12, 32'd20, 32'd32};
  logic [DATA_W-1:0] phase_init [PHASE_COUNT] = '{
    32'd500, 32'd250, 32'd0, 32'h000F_FFFF, 32'd1000000, 32'hFFFF_FFFF, 32'd700, 32'd500};
  logic [DATA_W-1:0] phase_max  [PHASE_COUNT] = '{
    32'd2000, 32'd600, 32'd0, 32'h000F_FFFF, 32'd1000000, 32'd5000, 32'd1300, 32'd0};

  slow_start_push_window_table i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .dest_index (dest_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .window     (window),
    .sleep_ms   (sleep_ms),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [WINDOW_W-1:0] bump(input logic [WINDOW_W-1:0] v);
    return (v == COUNT_TOP) ? v : v + 1'b1;
  endfunction

  function automatic push_answer_t advance_entry(input kind_t k,
                                                 input logic [DEST_W-1:0] d);
    push_answer_t res;
    int unsigned i;
    longint s;
    logic [WINDOW_W-1:0] w;
    res = '0;
    i = d % TABLE_DEPTH;
    if (k == KIND_CLEAR) begin
      live = '{default: 1'b0};
      return res;
    end
    if (!live[i]) begin
      live[i] = 1'b1;
      win_tab[i] = 1;
      thr_tab[i] = cfg_mif;
      avoid_tab[i] = '0;
      run_tab[i] = '0;
    end
    if (k == KIND_SUCCESS) begin
      run_tab[i] = '0;
      if (win_tab[i] >= thr_tab[i]) begin
        avoid_tab[i] = bump(avoid_tab[i]);
        if (avoid_tab[i] >= win_tab[i]) begin
          win_tab[i] = bump(win_tab[i]);
          avoid_tab[i] = '0;
        end
      end else begin
        win_tab[i] = bump(win_tab[i]);
      end
    end else if (k == KIND_CONGEST) begin
      if (win_tab[i] <= 1) begin
        win_tab[i] = 1;
        run_tab[i] = bump(run_tab[i]);
      end else begin
        win_tab[i] = win_tab[i] >> 1;
      end
      thr_tab[i] = win_tab[i];
      avoid_tab[i] = '0;
    end
    w = win_tab[i];
    res.window = w;
    if (w >= cfg_mif) begin
      s = 0;
    end else begin
      s = longint'(cfg_init_sleep) - longint'(STEP_CREDIT_MS) * longint'(w);
      if (w == 1) begin
        s = s + longint'(run_tab[i]) * longint'(RUN_PENALTY_MS);
        if (s > longint'(cfg_max_sleep)) begin
          s = longint'(cfg_max_sleep);
        end
      end
      if (s < 0) begin
        s = 0;
      end
    end
    res.sleep_ms = s[SLEEP_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predicted = advance_entry(kind_t'(kind), dest_index);
      if (row_given) begin
        predicted.window = row_win;
        predicted.sleep_ms = row_sleep;
      end
      owed_results.push_back(predicted);
      items_taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        $error("unexpected result: window %0d, sleep_ms %0d", window, sleep_ms);
        fail_count++;
      end else begin
        oldest = owed_results.pop_front();
        if (window !== oldest.window) begin
          $error("window: expected %0d, got %0d", oldest.window, window);
          fail_count++;
        end
        if (sleep_ms !== oldest.sleep_ms) begin
          $error("sleep_ms: expected %0d, got %0d", oldest.sleep_ms, sleep_ms);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_count <= 0;
    end else if (idle_count >= STALL_LIMIT) begin
      $display("tb_slow_start_push_window_table: errors");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  task automatic push_item(input kind_t k, input logic [DEST_W-1:0] d, input logic given,
                           input logic [WINDOW_W-1:0] w, input logic [SLEEP_W-1:0] s);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    dest_index <= d;
    row_given <= given;
    row_win <= w;
    row_sleep <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (owed_results.size() != 0) @(negedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    if (wr) begin
      case (addr)
        {REG_MAX_IN_FLIGHT, 2'b00}: cfg_mif = data[MIF_W-1:0];
        {REG_INITIAL_SLEEP, 2'b00}: cfg_init_sleep = data[SLEEP_W-1:0];
        {REG_MAX_SLEEP, 2'b00}:     cfg_max_sleep = data[SLEEP_W-1:0];
        default: ;
      endcase
    end
    @(negedge clk);
  endtask

  task automatic verify_regs();
    logic [DATA_W-1:0] rd;
    apb_xfer(1'b0, {REG_MAX_IN_FLIGHT, 2'b00}, '0, rd);
    if (rd !== DATA_W'(cfg_mif)) begin
      $error("max_in_flight: expected %0d, got %0d", cfg_mif, rd);
      fail_count++;
    end
    apb_xfer(1'b0, {REG_INITIAL_SLEEP, 2'b00}, '0, rd);
    if (rd !== DATA_W'(cfg_init_sleep)) begin
      $error("initial_sleep_ms: expected %0d, got %0d", cfg_init_sleep, rd);
      fail_count++;
    end
    apb_xfer(1'b0, {REG_MAX_SLEEP, 2'b00}, '0, rd);
    if (rd !== DATA_W'(cfg_max_sleep)) begin
      $error("max_sleep_ms: expected %0d, got %0d", cfg_max_sleep, rd);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [DATA_W-1:0] mif, input logic [DATA_W-1:0] init,
                            input logic [DATA_W-1:0] cap);
    logic [DATA_W-1:0] rd;
    apb_xfer(1'b1, {REG_MAX_IN_FLIGHT, 2'b00}, mif, rd);
    apb_xfer(1'b1, {REG_INITIAL_SLEEP, 2'b00}, init, rd);
    apb_xfer(1'b1, {REG_MAX_SLEEP, 2'b00}, cap, rd);
    verify_regs();
  endtask

  initial begin
    int r;
    kind_t k;
    logic [DEST_W-1:0] d;
    logic [DATA_W-1:0] rd;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_SUCCESS;
    dest_index = '0;
    row_given = 1'b0;
    row_win = '0;
    row_sleep = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    verify_regs();

    sender_idle_pct = 26;
    receiver_idle_pct = 83;
    foreach (directed_rows[n]) begin
      push_item(directed_rows[n].k, directed_rows[n].d, directed_rows[n].given,
                directed_rows[n].w, directed_rows[n].s);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain();
      if (p == 3) begin
        apb_xfer(1'b1, SPARE_ADDR, $urandom, rd);
      end
      set_config(phase_mif[p], phase_init[p], phase_max[p]);
      sender_idle_pct = (p < 3) ? 26 : (p < 6) ? 83 : 0;
      receiver_idle_pct = (p < 3) ? 83 : (p < 6) ? 26 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < 55) begin
          k = KIND_SUCCESS;
        end else if (r < 80) begin
          k = KIND_CONGEST;
        end else if (r < 97) begin
          k = KIND_QUERY;
        end else begin
          k = KIND_CLEAR;
        end
        d = ($urandom_range(3) == 0) ? DEST_W'($urandom_range(63)) : DEST_W'($urandom_range(7));
        push_item(k, d, 1'b0, '0, '0);
        if (p == 6 && n == 30) begin
          hold_cycles = LONG_HOLD;
        end
        if (p == 5 && n == 60) begin
          drain();
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Run covered %0d items and %0d results over %0d register settings,",
             items_taken, results_seen, PHASE_COUNT);
    $display("including zero and full-scale registers, a long output hold-off and a drain.");
    if (fail_count == 0) begin
      $display("tb_slow_start_push_window_table: clean");
    end else begin
      $display("tb_slow_start_push_window_table: errors");
    end
    $finish;
  end

endmodule
